FILE: rtl/core/lru_key_value_cache_defines.svh
// ---------------------------------------------------------------------------
// lru_key_value_cache assertion macros
// clocked concurrent checks on clk, with and without the reset qualifier
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is skipped while rst_n is low
`define LRU_KV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lru_kv check failed");
// check that also holds during reset
`define LRU_KV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lru_kv check failed");
`else
`define LRU_KV_ASSERT(lbl, prop)
`define LRU_KV_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/core/lru_kv_pkg.sv
// ---------------------------------------------------------------------------
// lru_kv_pkg
// shared types and codes for the lru key-value cache and its cells
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_kv_pkg;

  // configuration register width and reset value
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // which cell an update targets
  localparam logic [1:0] PICK_NONE   = 2'd0;
  localparam logic [1:0] PICK_HIT    = 2'd1;
  localparam logic [1:0] PICK_FREE   = 2'd2;
  localparam logic [1:0] PICK_VICTIM = 2'd3;

  // update command broadcast to every cell
  typedef struct packed {
    logic       en;
    logic [1:0] pick;
    logic       wr_key;
    logic       wr_val;
    logic       set_valid;
    logic       promote;
    logic       age_all;
  } upd_cmd_t;

endpackage

FILE: rtl/core/lru_kv_cell.sv
// ---------------------------------------------------------------------------
// lru_kv_cell
// one cache entry: key, value, recency rank, plus the lookup chain links
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_kv_cell #(
  parameter int unsigned RW         = 4,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  look_en,
  input  lru_kv_pkg::upd_cmd_t  cmd,
  input  logic [RW-1:0]         limit_i,
  input  logic [RW-1:0]         victim_rank_i,
  input  logic [KEY_BITS-1:0]   req_key_i,
  input  logic [VALUE_BITS-1:0] req_value_i,
  input  logic                  found_i,
  input  logic [RW-1:0]         rank_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  free_i,
  output logic                  found_o,
  output logic [RW-1:0]         rank_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  free_o,
  output logic                  valid_o,
  output logic                  match_o
);
  import lru_kv_pkg::*;

  logic                  valid_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [RW-1:0]         rank_r;
  logic                  match_r;
  logic                  free_r;
  logic                  victim_r;
  logic                  match;
  logic                  sel;
  logic                  ages;

  // local key compare
  assign match = valid_r && (key_r == req_key_i);

  // gather chain: hit flag, hit rank and hit value ripple to the next cell
  assign found_o = found_i | match;
  assign rank_o  = rank_i  | (match ? rank_r  : '0);
  assign value_o = value_i | (match ? value_r : '0);

  // free-slot chain: the first invalid cell from the low end wins
  assign free_o  = free_i | ~valid_r;

  assign valid_o = valid_r;
  assign match_o = match_r;

  // target select for this update
  always_comb begin
    unique case (cmd.pick)
      PICK_NONE:   sel = 1'b0;
      PICK_HIT:    sel = match_r;
      PICK_FREE:   sel = free_r;
      PICK_VICTIM: sel = victim_r;
    endcase
  end

  // valid entries ranked below the limit, or all of them on age_all, get one step older
  assign ages = valid_r && !sel && (cmd.age_all || (rank_r < limit_i));

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.en && sel && cmd.set_valid) begin
      valid_r <= 1'b1;
    end
  end

  // lookup flags, taken in the compare cycle
  always_ff @(posedge clk) begin
    if (look_en) begin
      match_r  <= match;
      free_r   <= ~valid_r & ~free_i;
      victim_r <= valid_r && (rank_r == victim_rank_i);
    end
  end

  // entry contents and recency
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (sel && cmd.wr_key) begin
        key_r <= req_key_i;
      end
      if (sel && cmd.wr_val) begin
        value_r <= req_value_i;
      end
      if (cmd.promote) begin
        if (sel) begin
          rank_r <= '0;
        end else if (ages) begin
          rank_r <= RW'(rank_r + 1'b1);
        end
      end
    end
  end

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// An accepted item makes a compare pass and then an update pass through the row of
// entry cells, and its result is registered by the update pass. A new item can be
// accepted in the update pass of the one before, but not in its compare pass.
// The update cycle waits while a finished result is held and stalled at the output.
// Reset (rst_n low, synchronous) empties every entry, clears the fill level and sets
// the capacity register to 16; no clearing pass follows.
// ---------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lru_kv_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic [VALUE_BITS-1:0]       in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [VALUE_BITS-1:0]       out_read_value
);
  import lru_kv_pkg::*;

  localparam int unsigned RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (UW > CAP_W) ? UW : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [UW-1:0]         used_r;
  logic [UW-1:0]         used_nxt;
  logic [UW-1:0]         used_m1;
  logic                  req_mode_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;
  logic                  hit_r;
  logic [RW-1:0]         hit_rank_r;
  logic [VALUE_BITS-1:0] hit_value_r;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_read_value_r;

  logic                  accept;
  logic                  upd_go;
  logic                  look_en;
  logic [EW-1:0]         eff_cap;
  logic                  has_room;
  upd_cmd_t              cmd;
  logic [RW-1:0]         limit;

  logic                  found_c [MAX_ENTRIES+1];
  logic [RW-1:0]         rank_c  [MAX_ENTRIES+1];
  logic [VALUE_BITS-1:0] value_c [MAX_ENTRIES+1];
  logic                  free_c  [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] match_vec;

  // handshake
  assign upd_go   = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_UPD) && upd_go));
  assign look_en  = (state_r == ST_LOOK);

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end else if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // effective capacity: zero acts as one, clipped to the entry count
  always_comb begin
    priority if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_r) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(cap_r);
    end
  end

  assign has_room = EW'(used_r) < eff_cap;
  assign used_m1  = used_r - UW'(1);

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r  <= in_mode;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
  end

  // lookup result from the end of the cell chain
  always_ff @(posedge clk) begin
    if (look_en) begin
      hit_r       <= found_c[MAX_ENTRIES];
      hit_rank_r  <= rank_c[MAX_ENTRIES];
      hit_value_r <= value_c[MAX_ENTRIES];
    end
  end

  // update command for the row of cells
  always_comb begin
    cmd           = '0;
    cmd.en        = (state_r == ST_UPD) && upd_go;
    cmd.pick      = PICK_NONE;
    limit         = hit_rank_r;
    used_nxt      = used_r;
    priority if (hit_r) begin
      cmd.pick    = PICK_HIT;
      cmd.wr_val  = req_mode_r;
      cmd.promote = 1'b1;
    end else if (!req_mode_r) begin
      cmd.pick    = PICK_NONE;
    end else if (has_room) begin
      cmd.pick      = PICK_FREE;
      cmd.wr_key    = 1'b1;
      cmd.wr_val    = 1'b1;
      cmd.set_valid = 1'b1;
      cmd.promote   = 1'b1;
      cmd.age_all   = 1'b1;
      used_nxt      = used_r + UW'(1);
    end else begin
      cmd.pick    = PICK_VICTIM;
      cmd.wr_key  = 1'b1;
      cmd.wr_val  = 1'b1;
      cmd.promote = 1'b1;
      limit       = used_m1[RW-1:0];
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.en) begin
      used_r <= used_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      out_hit_r        <= hit_r;
      out_read_value_r <= (hit_r && !req_mode_r) ? hit_value_r : '0;
    end
  end

  // chain heads
  assign found_c[0] = 1'b0;
  assign rank_c[0]  = '0;
  assign value_c[0] = '0;
  assign free_c[0]  = 1'b0;

  // row of entry cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lru_kv_cell #(
      .RW        (RW),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .look_en      (look_en),
      .cmd          (cmd),
      .limit_i      (limit),
      .victim_rank_i(used_m1[RW-1:0]),
      .req_key_i    (req_key_r),
      .req_value_i  (req_value_r),
      .found_i      (found_c[g]),
      .rank_i       (rank_c[g]),
      .value_i      (value_c[g]),
      .free_i       (free_c[g]),
      .found_o      (found_c[g+1]),
      .rank_o       (rank_c[g+1]),
      .value_o      (value_c[g+1]),
      .free_o       (free_c[g+1]),
      .valid_o      (valid_vec[g]),
      .match_o      (match_vec[g])
    );
  end

  // checks
  `LRU_KV_ASSERT(a_used_matches_valid, $countones(valid_vec) == int'(used_r))
  `LRU_KV_ASSERT(a_single_match, (state_r == ST_UPD) |-> $onehot0(match_vec))
  `LRU_KV_ASSERT(a_accept_to_look, accept |=> (state_r == ST_LOOK))
  `LRU_KV_ASSERT(a_result_after_update, $rose(out_valid_r) |-> $past(state_r == ST_UPD))
  `LRU_KV_ASSERT_ALWAYS(a_used_bound, !rst_n || (EW'(used_r) <= EW'(MAX_ENTRIES)))

endmodule

FILE: tb/sv/lru_key_value_cache_tb.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache_tb
// drives get and put items with random gaps and output stalls, predicts each
// result with a cycle-free model of the lru cache and compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lru_kv_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 32;

  // operation codes carried in in_mode
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 115;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_mode;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;

  // predicted cache contents
  logic             slot_valid [SLOTS];
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [VAL_W-1:0] slot_value [SLOTS];
  logic [3:0]       slot_rank  [SLOTS];
  logic [4:0]       slots_used;
  logic [CAP_W-1:0] capacity;

  lookup_result_t pending_results [$];
  int             fail_count   = 0;
  int             steady_items = 0;
  int             stall_left   = 0;
  int             clear_left   = 0;

  always #5 clk = ~clk;

  lru_key_value_cache #(
    .MAX_ENTRIES (SLOTS),
    .KEY_BITS    (KEY_W),
    .VALUE_BITS  (VAL_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

  // make slot s most recent; valid entries ranked below limit age by one
  function automatic void make_most_recent(int s, int limit);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < limit) slot_rank[i] = slot_rank[i] + 4'd1;
    end
    slot_rank[s] = '0;
  endfunction

  // apply one get or put to the predicted cache and return its result
  function automatic lookup_result_t cache_access(logic mode, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] value);
    lookup_result_t res;
    int found;
    int victim;
    int eff_cap;
    found = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key) found = i;
    end
    res.hit        = (found >= 0);
    res.read_value = '0;
    // zero acts as one, anything above the slot count as the slot count
    eff_cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
    if (found >= 0) begin
      if (mode == MODE_GET) res.read_value = slot_value[found];
      else slot_value[found] = value;
      make_most_recent(found, slot_rank[found]);
    end else if (mode == MODE_PUT) begin
      victim = -1;
      // lowest free slot while below capacity
      if (slots_used < eff_cap) begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_valid[i]) victim = i;
        end
      end
      if (victim >= 0) begin
        slot_valid[victim] = 1'b1;
        slot_key[victim]   = key;
        slot_value[victim] = value;
        make_most_recent(victim, SLOTS);
        slots_used = slots_used + 5'd1;
      end else begin
        // evict the least recent entry, first one wins a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          slot_key[victim]   = key;
          slot_value[victim] = value;
          make_most_recent(victim, slot_rank[victim]);
        end
      end
    end
    return res;
  endfunction

  // send one item after a random gap and record its prediction on acceptance
  task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    int gap;
    int r;
    gap = 0;
    if (steady_items > 0) begin
      steady_items--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) steady_items = $urandom_range(20, 60);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 96) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(cache_access(mode, key, value));
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      fail_count++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // capacity write while the cache is idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    capacity = cap;
    cfg_wr_en <= 1'b0;
  endtask

  // reset capacity: misses on empty, fills, hits, updates, field extremes
  task automatic test_basics();
    send_item(MODE_GET, 16'h0000, 32'hFFFF_FFFF);
    send_item(MODE_PUT, 16'h0000, 32'h0000_0000);
    send_item(MODE_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(MODE_GET, 16'hFFFF, 32'h0000_0000);
    send_item(MODE_GET, 16'h0000, 32'h1234_5678);
    send_item(MODE_PUT, 16'h0000, 32'hA5A5_A5A5);
    send_item(MODE_GET, 16'h0000, 32'h0000_0000);
    send_item(MODE_GET, 16'h8001, 32'h0000_0000);
    send_item(MODE_PUT, 16'h8001, 32'h0000_0001);
    wait_for_drain();
  endtask

  // capacity below the fill level, zero capacity and oversized capacity
  task automatic test_capacity_limits();
    write_capacity(5'd1);
    send_item(MODE_PUT, 16'h1234, 32'hDEAD_BEEF);
    send_item(MODE_GET, 16'hFFFF, 32'h0000_0000);
    send_item(MODE_GET, 16'h8001, 32'h0000_0000);
    send_item(MODE_PUT, 16'h4321, 32'h5A5A_5A5A);
    wait_for_drain();
    write_capacity(5'd0);
    send_item(MODE_PUT, 16'h5555, 32'h8000_0000);
    send_item(MODE_GET, 16'h5555, 32'h0000_0000);
    wait_for_drain();
    write_capacity(5'd31);
    send_item(MODE_PUT, 16'h0F0F, 32'h7FFF_FFFF);
    send_item(MODE_PUT, 16'hF0F0, 32'h0000_FFFF);
    send_item(MODE_GET, 16'h1234, 32'h0000_0000);
    send_item(MODE_GET, 16'hF0F0, 32'h0000_0000);
    wait_for_drain();
  endtask

  // random gets and puts over a working set a little larger than capacity
  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap_plan [14];
    logic [KEY_W-1:0] key_pool [24];
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] key;
    logic             mode;
    int               pool_n;
    cap_plan = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd4, 5'd17, 5'd8,
                 5'd9, 5'd3, 5'd15, 5'd16, 5'd24, 5'd6};
    for (int j = 0; j < 24; j++) key_pool[j] = KEY_W'($urandom);
    for (int p = 0; p < 14; p++) begin
      if (p % 4 == 3) cap = CAP_W'($urandom_range(0, 31));
      else cap = cap_plan[p];
      // keep about half the keys so resident entries still get hits
      for (int j = 0; j < 24; j++) begin
        if ($urandom_range(0, 1) == 1) key_pool[j] = KEY_W'($urandom);
      end
      pool_n = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap) + $urandom_range(1, 6);
      write_capacity(cap);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(0, 99) < 45) ? MODE_PUT : MODE_GET;
        if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, pool_n - 1)];
        else key = KEY_W'($urandom);
        send_item(mode, key, $urandom);
      end
      wait_for_drain();
    end
  endtask

  // output stall: short bursts, a few long ones, and quiet stretches
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (clear_left > 0) begin
      out_stall <= 1'b0;
      clear_left--;
    end else if (r < 8) begin
      out_stall <= 1'b0;
      clear_left = $urandom_range(20, 80);
    end else if (r < 12) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(10, 40);
    end else if (r < 40) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          fail_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_read_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_mode     = MODE_GET;
    in_key      = '0;
    in_value    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_rank[i]  = '0;
    end
    slots_used = '0;
    capacity   = CAP_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_basics();
    test_capacity_limits();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(10_000_000);
    $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule
